[rtl/core/ptc_pkg.sv]
// Shared types, constants and arithmetic helpers for the compensation unit.
package ptc_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CAL_TEMPERATURE   = 2'd0,
        CFG_CAL_PRESSURE_LOW  = 2'd1,
        CFG_CAL_PRESSURE_HIGH = 2'd2,
        CFG_CAL_PRESSURE_NINE = 2'd3
    } ptc_cfg_e;

    localparam int QUEUE_DEPTH = 4;
    localparam int DIV_STEPS   = 64;
    localparam int POST_STAGES = 8;

    localparam logic signed [24:0] FINE_OFFSET = 25'sd128000;
    localparam logic [20:0]        P_BASE      = 21'h100000;
    localparam logic [11:0]        P_SCALE     = 12'd3125;
    localparam logic [63:0]        P_BIAS      = 64'h0000_8000_0000_0000;
    localparam logic signed [26:0] CENTI_MUL   = 27'sd5;
    localparam logic signed [26:0] CENTI_RND   = 27'sd128;

    // Item handed from the front end to the back end
    typedef struct packed {
        logic [19:0] raw_p;
        logic [23:0] fine;
        logic [23:0] centi;
    } ptc_item_t;

    // Temperature results riding along with the pressure pipeline
    typedef struct packed {
        logic [23:0] fine;
        logic [23:0] centi;
    } ptc_side_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ptc_qstat_t;

    // One stage of the restoring divider
    typedef struct packed {
        logic        vld;
        logic        qneg;
        logic        dzero;
        ptc_side_t   side;
        logic [30:0] md;
        logic [30:0] rem;
        logic [63:0] num;
    } ptc_div_stage_t;

    function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
        logic signed [63:0] sx;
        sx = $signed(x);
        return 64'(sx >>> n);
    endfunction

    function automatic logic [63:0] sext16(input logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    // One quotient bit: shift in the next numerator bit, subtract if it fits
    function automatic ptc_div_stage_t div_step(input ptc_div_stage_t s);
        ptc_div_stage_t r;
        logic [31:0]    cand;
        logic [31:0]    diff;
        r    = s;
        cand = {s.rem, s.num[63]};
        diff = cand - {1'b0, s.md};
        r.num = {s.num[62:0], 1'b0};
        if (cand >= {1'b0, s.md}) begin
            r.rem    = diff[30:0];
            r.num[0] = 1'b1;
        end else begin
            r.rem = cand[30:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/ptc_queue.sv]
// Short FIFO between the temperature front end and the pressure back end.
module ptc_queue #(
    parameter int DEPTH = ptc_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ptc_pkg::ptc_item_t push_data,
    input  logic               pop,
    output ptc_pkg::ptc_item_t pop_data,
    output ptc_pkg::ptc_qstat_t qstat
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    ptc_pkg::ptc_item_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data    = entry_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == FULL);
    assign qstat.empty = (count_reg == '0);

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != FULL))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("queue pop while empty");

endmodule

[rtl/core/ptc_front.sv]
// Front end: accept raw samples and compute fine and centi temperature.
module ptc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [47:0]         cal_t,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [19:0]         raw_p,
    input  logic [19:0]         raw_t,
    input  ptc_pkg::ptc_qstat_t qstat,
    output logic                push,
    output ptc_pkg::ptc_item_t  push_data
);
    localparam logic signed [26:0] CENTI_MUL_L = ptc_pkg::CENTI_MUL;
    localparam logic signed [26:0] CENTI_RND_L = ptc_pkg::CENTI_RND;

    logic [15:0]        t1;
    logic signed [15:0] t2, t3;
    logic               adv;
    logic [5:1]         vld_reg;

    logic signed [17:0] diff_c;
    logic signed [16:0] dt_c;
    logic signed [33:0] a_sh_c;
    logic signed [37:0] b37_c, b_sh_c;
    logic signed [26:0] f5_c, c_sh_c;

    logic [19:0]        p_reg [1:5];
    logic signed [17:0] diff_reg;
    logic signed [16:0] dt_reg;
    logic signed [33:0] a34_reg, dd_reg;
    logic signed [22:0] a_reg;
    logic signed [37:0] b37_reg;
    logic signed [23:0] fine_reg [4:5];
    logic [23:0]        centi_reg;

    assign t1 = cal_t[15:0];
    assign t2 = $signed(cal_t[31:16]);
    assign t3 = $signed(cal_t[47:32]);

    // Stall only when the last stage holds an item the queue cannot take
    assign adv      = !(vld_reg[5] && qstat.full);
    assign in_ready = adv;
    assign push     = vld_reg[5] && !qstat.full;

    always_comb begin
        diff_c = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, t1, 1'b0});
        dt_c   = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, t1});
        a_sh_c = a34_reg >>> 11;
        b37_c  = $signed({1'b0, dd_reg[32:12]}) * t3;
        b_sh_c = b37_reg >>> 14;
        f5_c   = fine_reg[4] * CENTI_MUL_L + CENTI_RND_L;
        c_sh_c = f5_c >>> 8;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[4:1], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_reg[1]    <= raw_p;
            diff_reg    <= diff_c;
            dt_reg      <= dt_c;
            p_reg[2]    <= p_reg[1];
            a34_reg     <= diff_reg * t2;
            dd_reg      <= dt_reg * dt_reg;
            p_reg[3]    <= p_reg[2];
            a_reg       <= a_sh_c[22:0];
            b37_reg     <= b37_c;
            p_reg[4]    <= p_reg[3];
            fine_reg[4] <= {a_reg[22], a_reg} + b_sh_c[23:0];
            p_reg[5]    <= p_reg[4];
            fine_reg[5] <= fine_reg[4];
            centi_reg   <= c_sh_c[23:0];
        end
    end

    assign push_data.raw_p = p_reg[5];
    assign push_data.fine  = fine_reg[5];
    assign push_data.centi = centi_reg;

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> (vld_reg[5] && qstat.full))
        else $error("front stalled without a full queue");

endmodule

[rtl/core/ptc_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module ptc_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  ptc_pkg::ptc_div_stage_t div_in,
    output ptc_pkg::ptc_div_stage_t div_out
);
    localparam int N = ptc_pkg::DIV_STEPS;

    ptc_pkg::ptc_div_stage_t st_reg [1:N];
    ptc_pkg::ptc_div_stage_t st_c   [0:N-1];

    always_comb begin
        st_c[0] = div_in;
        for (int k = 1; k < N; k++) begin
            st_c[k] = st_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= N; k++) begin
                st_reg[k].vld <= 1'b0;
            end
        end else if (adv) begin
            for (int k = 1; k <= N; k++) begin
                st_reg[k] <= ptc_pkg::div_step(st_c[k-1]);
            end
        end
    end

    assign div_out = st_reg[N];

endmodule

[rtl/core/ptc_back.sv]
// Back end: 64-bit pressure polynomial, signed division and output register.
module ptc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [63:0]         cal_pl,
    input  logic [63:0]         cal_ph,
    input  logic [15:0]         cal_p9,
    input  ptc_pkg::ptc_qstat_t qstat,
    output logic                pop,
    input  ptc_pkg::ptc_item_t  pop_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [23:0]         temperature_centi,
    output logic [23:0]         fine_temperature,
    output logic [31:0]         pressure_q24_8,
    output logic                pressure_valid
);
    localparam int NP = ptc_pkg::POST_STAGES;

    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p5, p6, p8, p9;
    logic               adv;

    // Pre-divider stages 1..8
    logic [7:1]          pre_vld_reg;
    ptc_pkg::ptc_side_t  pre_side_reg [1:7];
    logic [19:0]         adcp_reg [1:4];
    logic signed [24:0]  v1_reg;
    logic signed [49:0]  sq_reg;
    logic signed [40:0]  v1p5_reg [2:3];
    logic signed [40:0]  v1p2_reg [2:3];
    logic [63:0]         m6_reg, m3_reg, v2_reg, v1b_reg, y_reg, x_reg;
    logic [47:0]         yl_reg;
    logic [31:0]         yh_reg, xh_reg;
    logic [43:0]         xl_reg;
    logic [63:0]         den_reg, num_reg;
    ptc_pkg::ptc_div_stage_t b8_reg;

    // Post-divider stages 0..7 and output
    logic [NP-1:0]       post_vld_reg;
    logic [NP-1:0]       post_dz_reg;
    ptc_pkg::ptc_side_t  post_side_reg [NP];
    logic [63:0]         q_reg [6];
    logic [63:0]         ps_reg, e2raw_reg, ll_reg, sq2_reg, e1raw_reg, s_reg, r_reg;
    logic [63:0]         e2_reg [3:5];
    logic signed [48:0]  e2lo_reg, e1lo_reg;
    logic [31:0]         e2hi_reg, lh_reg, e1hi_reg;
    logic                out_vld_reg;
    ptc_pkg::ptc_side_t  out_side_reg;
    logic [31:0]         out_pq_reg;
    logic                out_pv_reg;

    ptc_pkg::ptc_div_stage_t div_out;

    logic signed [65:0]  m6_c, m3_c;
    logic [20:0]         p21_c;
    logic [31:0]         yh_c;
    logic [31:0]         xh_c;
    logic [63:0]         den_c, q_c, sum_y_c;
    logic [31:0]         e2hi_c, e1hi_c;
    logic [31:0]         lh_c;
    logic                pv_c;
    logic [31:0]         pq_c;

    assign p1 = cal_pl[15:0];
    assign p2 = $signed(cal_pl[31:16]);
    assign p3 = $signed(cal_pl[47:32]);
    assign p5 = $signed(cal_ph[15:0]);
    assign p6 = $signed(cal_ph[31:16]);
    assign p8 = $signed(cal_ph[63:48]);
    assign p9 = $signed(cal_p9);

    // The whole back end advances together; hold everything while the result waits
    assign adv = !out_vld_reg || out_ready;
    assign pop = adv && !qstat.empty;

    always_comb begin
        m6_c    = sq_reg * p6;
        m3_c    = sq_reg * p3;
        p21_c   = ptc_pkg::P_BASE - {1'b0, adcp_reg[4]};
        yh_c    = y_reg[63:32] * {16'b0, p1};
        xh_c    = x_reg[63:32] * {20'b0, ptc_pkg::P_SCALE};
        sum_y_c = {16'b0, yl_reg} + {yh_reg, 32'b0};
        den_c   = ptc_pkg::asr64(sum_y_c, 33);
        q_c     = div_out.qneg ? (64'd0 - div_out.num) : div_out.num;
        // high partials take the sign-extended calibration word, low 32 bits kept
        e2hi_c  = q_reg[0][63:32] * {{16{cal_ph[63]}}, cal_ph[63:48]};
        lh_c    = ps_reg[31:0] * ps_reg[63:32];
        e1hi_c  = sq2_reg[63:32] * {{16{cal_p9[15]}}, cal_p9};
        pv_c    = !post_dz_reg[NP-1] && !r_reg[63] && (r_reg != 64'd0);
        pq_c    = 32'd0;
        if (pv_c) begin
            pq_c = (r_reg[63:32] != 32'd0) ? 32'hFFFF_FFFF : r_reg[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_vld_reg  <= '0;
            post_vld_reg <= '0;
            out_vld_reg  <= 1'b0;
        end else if (adv) begin
            pre_vld_reg  <= {pre_vld_reg[6:1], pop};
            post_vld_reg <= {post_vld_reg[NP-2:0], div_out.vld};
            out_vld_reg  <= post_vld_reg[NP-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage 1: offset the fine temperature
            pre_side_reg[1].fine  <= pop_data.fine;
            pre_side_reg[1].centi <= pop_data.centi;
            adcp_reg[1] <= pop_data.raw_p;
            v1_reg      <= $signed({pop_data.fine[23], pop_data.fine}) - ptc_pkg::FINE_OFFSET;
            // stage 2: square and linear terms
            pre_side_reg[2] <= pre_side_reg[1];
            adcp_reg[2]     <= adcp_reg[1];
            sq_reg          <= v1_reg * v1_reg;
            v1p5_reg[2]     <= v1_reg * p5;
            v1p2_reg[2]     <= v1_reg * p2;
            // stage 3: quadratic terms
            pre_side_reg[3] <= pre_side_reg[2];
            adcp_reg[3]     <= adcp_reg[2];
            m6_reg          <= m6_c[63:0];
            m3_reg          <= m3_c[63:0];
            v1p5_reg[3]     <= v1p5_reg[2];
            v1p2_reg[3]     <= v1p2_reg[2];
            // stage 4: sum into var2 and var1
            pre_side_reg[4] <= pre_side_reg[3];
            adcp_reg[4]     <= adcp_reg[3];
            v2_reg  <= m6_reg + ({{23{v1p5_reg[3][40]}}, v1p5_reg[3]} << 17)
                     + (ptc_pkg::sext16(cal_pl[63:48]) << 35);
            v1b_reg <= ptc_pkg::asr64(m3_reg, 8)
                     + ({{23{v1p2_reg[3][40]}}, v1p2_reg[3]} << 12);
            // stage 5: bias var1, form the numerator base
            pre_side_reg[5] <= pre_side_reg[4];
            y_reg <= ptc_pkg::P_BIAS + v1b_reg;
            x_reg <= {12'b0, p21_c, 31'b0} - v2_reg;
            // stage 6: partial products of the 64x16 and 64x12 multiplies
            pre_side_reg[6] <= pre_side_reg[5];
            yl_reg <= y_reg[31:0] * p1;
            yh_reg <= yh_c;
            xl_reg <= x_reg[31:0] * ptc_pkg::P_SCALE;
            xh_reg <= xh_c;
            // stage 7: divisor and numerator
            pre_side_reg[7] <= pre_side_reg[6];
            den_reg <= den_c;
            num_reg <= {20'b0, xl_reg} + {xh_reg, 32'b0};
            // stage 8: split into sign and magnitude for the divider
            b8_reg.vld   <= pre_vld_reg[7];
            b8_reg.side  <= pre_side_reg[7];
            b8_reg.qneg  <= num_reg[63] ^ den_reg[63];
            b8_reg.dzero <= (den_reg == 64'd0);
            b8_reg.md    <= den_reg[63] ? 31'(64'd0 - den_reg) : den_reg[30:0];
            b8_reg.rem   <= '0;
            b8_reg.num   <= num_reg[63] ? (64'd0 - num_reg) : num_reg;

            // post 0: restore the quotient sign
            post_side_reg[0] <= div_out.side;
            post_dz_reg[0]   <= div_out.dzero;
            q_reg[0]         <= q_c;
            for (int k = 1; k < NP; k++) begin
                post_side_reg[k] <= post_side_reg[k-1];
                post_dz_reg[k]   <= post_dz_reg[k-1];
            end
            for (int k = 1; k < 6; k++) begin
                q_reg[k] <= q_reg[k-1];
            end
            // post 1: scaled pressure and P8 partials
            ps_reg   <= ptc_pkg::asr64(q_reg[0], 13);
            e2lo_reg <= $signed({1'b0, q_reg[0][31:0]}) * p8;
            e2hi_reg <= e2hi_c;
            // post 2: square of the scaled pressure
            e2raw_reg <= {{15{e2lo_reg[48]}}, e2lo_reg} + {e2hi_reg, 32'b0};
            ll_reg    <= ps_reg[31:0] * ps_reg[31:0];
            lh_reg    <= lh_c;
            // post 3
            sq2_reg   <= ll_reg + {lh_reg[30:0], 1'b0, 32'b0};
            e2_reg[3] <= ptc_pkg::asr64(e2raw_reg, 19);
            // post 4: P9 partials
            e1lo_reg  <= $signed({1'b0, sq2_reg[31:0]}) * p9;
            e1hi_reg  <= e1hi_c;
            e2_reg[4] <= e2_reg[3];
            // post 5
            e1raw_reg <= {{15{e1lo_reg[48]}}, e1lo_reg} + {e1hi_reg, 32'b0};
            e2_reg[5] <= e2_reg[4];
            // post 6
            s_reg <= q_reg[5] + ptc_pkg::asr64(e1raw_reg, 25) + e2_reg[5];
            // post 7
            r_reg <= ptc_pkg::asr64(s_reg, 8) + (ptc_pkg::sext16(cal_ph[47:32]) << 4);
            // output register
            out_side_reg <= post_side_reg[NP-1];
            out_pq_reg   <= pq_c;
            out_pv_reg   <= pv_c;
        end
    end

    ptc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .div_in  (b8_reg),
        .div_out (div_out)
    );

    assign out_valid         = out_vld_reg;
    assign temperature_centi = out_side_reg.centi;
    assign fine_temperature  = out_side_reg.fine;
    assign pressure_q24_8    = out_pq_reg;
    assign pressure_valid    = out_pv_reg;

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !pressure_valid) |-> (pressure_q24_8 == 32'd0))
        else $error("invalid pressure with nonzero value");
    a_pop_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> pre_vld_reg[1])
        else $error("popped item lost at first back stage");

endmodule

[rtl/core/pressure_temperature_compensation_unit.sv]
// Top level of the pressure and temperature compensation unit.
//
// Takes one raw 20-bit pressure and temperature pair per item and returns the
// fine temperature, the temperature in hundredths of a degree, and pressure in
// pascals as unsigned Q24.8 with a valid flag (tuser). The unit accepts one item
// every cycle and returns one result every cycle unless m_tready holds it back.
// The 64-stage restoring divider produces one quotient bit per stage. A
// five-stage temperature front end feeds a short queue, so input keeps flowing
// while a finished result waits on m_tready, until the queue fills. Calibration
// words are written through cfg_we/cfg_index/cfg_wdata; the user must write them
// only while the unit is idle, as the unit does not enforce it. All reset to zero.
module pressure_temperature_compensation_unit #(
    parameter int QUEUE_DEPTH = ptc_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // raw_pressure[19:0], raw_temperature[39:20]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // temperature_centi[23:0], fine_temperature[47:24],
                                   // pressure_q24_8[79:48]
    output logic        m_tuser    // pressure_valid
);
    logic [47:0] cal_t_reg;
    logic [63:0] cal_pl_reg;
    logic [63:0] cal_ph_reg;
    logic [15:0] cal_p9_reg;

    logic                push, pop;
    ptc_pkg::ptc_item_t  push_data, pop_data;
    ptc_pkg::ptc_qstat_t qstat;

    logic [23:0] centi, fine;
    logic [31:0] pq;
    logic        pv;

    // Calibration registers: store each write at its index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_t_reg  <= '0;
            cal_pl_reg <= '0;
            cal_ph_reg <= '0;
            cal_p9_reg <= '0;
        end else if (cfg_we) begin
            case (ptc_pkg::ptc_cfg_e'(cfg_index))
                ptc_pkg::CFG_CAL_TEMPERATURE:   cal_t_reg  <= cfg_wdata[47:0];
                ptc_pkg::CFG_CAL_PRESSURE_LOW:  cal_pl_reg <= cfg_wdata;
                ptc_pkg::CFG_CAL_PRESSURE_HIGH: cal_ph_reg <= cfg_wdata;
                ptc_pkg::CFG_CAL_PRESSURE_NINE: cal_p9_reg <= cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: temperature polynomial
    ptc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cal_t     (cal_t_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .raw_p     (s_tdata[19:0]),
        .raw_t     (s_tdata[39:20]),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    // Decoupling queue
    ptc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    // Back end: pressure polynomial, division, output register
    ptc_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cal_pl            (cal_pl_reg),
        .cal_ph            (cal_ph_reg),
        .cal_p9            (cal_p9_reg),
        .qstat             (qstat),
        .pop               (pop),
        .pop_data          (pop_data),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .temperature_centi (centi),
        .fine_temperature  (fine),
        .pressure_q24_8    (pq),
        .pressure_valid    (pv)
    );

    assign m_tdata = {pq, fine, centi};
    assign m_tuser = pv;

endmodule
